/* rtl/sfx_pkg.sv */
// shared types and constants for the sync frame xor deframer
package sfx_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned PAYLOAD_BYTES = 6;
	localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
	localparam int unsigned PAYLOAD_FIRST = 2;
	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

	typedef logic [BYTE_W-1:0] byte_t;

	// packed struct: batt_volt sits in the lowest bits
	typedef struct packed {
		logic signed [15:0] panel_amp;
		logic [15:0]        panel_volt;
		logic [15:0]        batt_volt;
	} payload_t;

	// frame tracker to output stage
	typedef struct packed {
		logic     emit;
		payload_t payload;
	} frame_res_t;

endpackage

/* rtl/sync_frame_xor_deframer.sv */
// top level of the sync frame xor deframer
// Takes one received serial byte per word on the slave stream and hunts for
// sync_value while idle. A frame of FRAME_BYTES bytes begins with the sync byte;
// every byte except the last is xored together and the last byte must equal
// that xor. A good frame gives one master word holding frame bytes 2..7 as
// three little-endian 16-bit fields; a bad one is dropped silently. Bytes
// move through an input register and a result register, one word per cycle
// sustained: a byte is taken every cycle, and the only stall is a good frame's
// final byte waiting in the input register while the result register still
// holds an untaken word. A frame's last byte passes through the input register,
// then its result is held in the result register. sync_value is written through
// cfg_we / cfg_wdata, reset 0xAA, and takes effect at the next frame start.
module sync_frame_xor_deframer import sfx_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: sync value
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [15:0] batt_volt, [31:16] panel_volt,
	                               // [47:32] panel_amp
);

	byte_t      sync_q;
	logic       valid_s1;
	byte_t      byte_s1;
	logic       advance_s1;
	logic       out_free;
	frame_res_t res;

	// sync value register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// input stage moves on unless it would emit into a full result register
	assign advance_s1 = valid_s1 && (!res.emit || out_free);
	assign s_tready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// frame tracking on the registered byte
	sfx_frame #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (advance_s1),
		.rx_byte    (byte_s1),
		.sync_value (sync_q),
		.res        (res)
	);

	// result register
	sfx_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance_s1 && res.emit),
		.payload  (res.payload),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* rtl/sfx_frame.sv */
// frame tracker: byte position, running xor and payload capture
module sfx_frame import sfx_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  byte_t      rx_byte,
	input  byte_t      sync_value,
	output frame_res_t res
);

	localparam int unsigned POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	byte_t            xor_q;
	logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] lanes_q;

	logic idle_drop;
	logic at_last;

	assign idle_drop = (pos_q == '0) && (rx_byte != sync_value);
	assign at_last   = (pos_q == POS_LAST);

	assign res.emit    = at_last && (xor_q == rx_byte);
	assign res.payload = payload_t'(lanes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			xor_q <= '0;
		end else if (byte_en && !idle_drop) begin
			if (at_last) begin
				pos_q <= '0;
				xor_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				xor_q <= xor_q ^ rx_byte;
			end
		end
	end

	// payload lanes, byte 2 of the frame in lane 0
	for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_lane
		always_ff @(posedge clk) begin
			if (byte_en && !idle_drop && !at_last &&
			    (pos_q == POS_W'(PAYLOAD_FIRST + i))) begin
				lanes_q[i] <= rx_byte;
			end
		end
	end

endmodule

/* rtl/sfx_out_reg.sv */
// result register on the master side
module sfx_out_reg import sfx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  payload_t         payload,
	output logic             out_free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [PAYLOAD_W-1:0] m_tdata
);

	logic     valid_q;
	payload_t data_q;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = PAYLOAD_W'(data_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= payload;
		end
	end

endmodule

/* rtl/sfx_checker.sv */
// port-level checks for the sync frame xor deframer, bound to the top level
module sfx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no result once reset has been seen
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	// input side never stalls while the result side can take a word
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with free result register");

endmodule

bind sync_frame_xor_deframer sfx_checker u_sfx_checker (.*);
